[hdl/rbe_pkg.sv]
// rbe_pkg: shared types, constants, microcode table and saturation helper
// for the rigid body euler step block. No dependencies.
package rbe_pkg;

  localparam int AXES      = 3;
  localparam int AXIS_W    = 2;
  localparam int MASS_W    = 31;
  localparam int DRAG_W    = 25;
  localparam int STEP_W    = 17;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int MA_W      = 42;   // multiplier operand a, signed
  localparam int MB_W      = 25;   // multiplier operand b, unsigned
  localparam int PROD_W    = 64;
  localparam int GRAV_W    = 33;
  localparam int DIV_N     = 49;   // dividend magnitude bits
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);
  localparam int QUOT_W    = DIV_N + 1;
  localparam int PC_W      = 5;

  localparam logic [MASS_W-1:0] MASS_RST  = 31'd65536;
  localparam logic [STEP_W-1:0] STEP_RST  = 17'd544;
  localparam logic [STEP_W-1:0] GSTEP_RST = 17'd800;
  localparam logic [MB_W-1:0]   Q_ONE     = 25'd65536;

  localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FORCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    FM_FORCE      = 2'd0,
    FM_ACCEL      = 2'd1,
    FM_IMPULSE    = 2'd2,
    FM_VEL_CHANGE = 2'd3
  } force_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS         = 3'd0,
    CFG_DRAG         = 3'd1,
    CFG_USE_GRAVITY  = 3'd2,
    CFG_CONSTRAINT   = 3'd3,
    CFG_KINEMATIC    = 3'd4,
    CFG_STEP_SIZE    = 3'd5,
    CFG_GRAVITY_STEP = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MA_FORCE, MA_VEL, MA_ACC, MA_MASS
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_STEP, MB_DRAG, MB_GSTEP, MB_FSCALE
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_PROD_Q, ACC_QUOT, ACC_FORCE
  } acc_op_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_GRAV, ST_POS, ST_VEL_SUB, ST_VEL_ADD
  } st_op_t;

  typedef enum logic [3:0] {
    JC_NONE, JC_ALWAYS, JC_IN_XFER, JC_CMD_FORCE, JC_KINEM,
    JC_MODE_VC, JC_MODE_ACC, JC_DIV_IDLE, JC_AXIS_MORE, JC_OUT_FREE
  } jcond_t;

  typedef logic [AXES-1:0][31:0] axis_vec_t;

  // one microcode word
  typedef struct packed {
    logic            rdy;
    mul_a_t          mul_a;
    mul_b_t          mul_b;
    logic            mul_en;
    acc_op_t         acc_op;
    st_op_t          st_op;
    logic            div_start;
    logic            axis_step;
    logic            out_load;
    jcond_t          jc;
    logic            hold;      // stay on this word while the jump condition is false
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic        cmd_force;
    force_mode_t mode;
    logic        axis_more;
  } dp_stat_t;

  typedef struct packed {
    dp_stat_t dp;
    logic     in_xfer;
    logic     kinematic;
    logic     div_idle;
    logic     out_free;
  } seq_stat_t;

  // program labels
  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_DECODE    = 5'd1;
  localparam logic [PC_W-1:0] PC_TICK_LOOP = 5'd5;
  localparam logic [PC_W-1:0] PC_OUT       = 5'd10;
  localparam logic [PC_W-1:0] PC_FORCE     = 5'd11;
  localparam logic [PC_W-1:0] PC_DIV_WAIT  = 5'd14;
  localparam logic [PC_W-1:0] PC_DIV_DONE  = 5'd15;
  localparam logic [PC_W-1:0] PC_ACCEL     = 5'd16;
  localparam logic [PC_W-1:0] PC_VC        = 5'd17;
  localparam logic [PC_W-1:0] PC_VEL_ADD   = 5'd18;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      5'd0: begin
        w.rdy = 1'b1; w.jc = JC_IN_XFER; w.target = PC_DECODE; w.hold = 1'b1;
      end
      5'd1: begin
        w.jc = JC_CMD_FORCE; w.target = PC_FORCE;
      end
      5'd2: begin
        w.jc = JC_KINEM; w.target = PC_OUT;
      end
      5'd3: begin
        w.mul_a = MA_MASS; w.mul_b = MB_GSTEP; w.mul_en = 1'b1;
      end
      5'd4: begin
        w.st_op = ST_GRAV;
      end
      5'd5: begin
        w.st_op = ST_POS; w.mul_a = MA_VEL; w.mul_b = MB_DRAG; w.mul_en = 1'b1;
      end
      5'd6: begin
        w.acc_op = ACC_PROD_Q;
      end
      5'd7: begin
        w.mul_a = MA_ACC; w.mul_b = MB_STEP; w.mul_en = 1'b1;
      end
      5'd8: begin
        w.acc_op = ACC_PROD_Q;
      end
      5'd9: begin
        w.st_op = ST_VEL_SUB; w.axis_step = 1'b1;
        w.jc = JC_AXIS_MORE; w.target = PC_TICK_LOOP;
      end
      5'd10: begin
        w.out_load = 1'b1; w.jc = JC_OUT_FREE; w.target = PC_IDLE; w.hold = 1'b1;
      end
      5'd11: begin
        w.jc = JC_MODE_VC; w.target = PC_VC;
      end
      5'd12: begin
        w.mul_a = MA_FORCE; w.mul_b = MB_FSCALE; w.mul_en = 1'b1;
        w.jc = JC_MODE_ACC; w.target = PC_ACCEL;
      end
      5'd13: begin
        w.div_start = 1'b1;
      end
      5'd14: begin
        w.jc = JC_DIV_IDLE; w.target = PC_DIV_DONE; w.hold = 1'b1;
      end
      5'd15: begin
        w.acc_op = ACC_QUOT; w.jc = JC_ALWAYS; w.target = PC_VEL_ADD;
      end
      5'd16: begin
        w.acc_op = ACC_PROD_Q; w.jc = JC_ALWAYS; w.target = PC_VEL_ADD;
      end
      5'd17: begin
        w.acc_op = ACC_FORCE;
      end
      5'd18: begin
        w.st_op = ST_VEL_ADD; w.axis_step = 1'b1;
        w.jc = JC_AXIS_MORE; w.target = PC_FORCE;
      end
      5'd19: begin
        w.jc = JC_ALWAYS; w.target = PC_OUT;
      end
      default: begin
        w.jc = JC_ALWAYS; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) r = 32'h7fff_ffff;
    else if (v < SAT_MIN) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hdl/rbe_div.sv]
// rbe_div: restoring divider, one quotient bit per cycle, signed dividend
// over unsigned divisor, truncating toward zero. Uses rbe_pkg.
module rbe_div import rbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] dividend,
  input  logic [MASS_W-1:0]        divisor,
  output logic                     busy,
  output logic signed [QUOT_W-1:0] quot
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N-1:0]     quo_r, quo_nxt;
  logic [MASS_W-1:0]    rem_r, rem_nxt;
  logic [MASS_W-1:0]    den_r;
  logic                 neg_r;
  logic [PROD_W-1:0]    mag;
  logic [MASS_W:0]      trial;

  assign mag   = dividend[PROD_W-1] ? -dividend : dividend;
  assign trial = {rem_r, quo_r[DIV_N-1]};

  always_comb begin
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = MASS_W'(trial - {1'b0, den_r});
      quo_nxt = {quo_r[DIV_N-2:0], 1'b1};
    end else begin
      rem_nxt = trial[MASS_W-1:0];
      quo_nxt = {quo_r[DIV_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_N);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag[DIV_N-1:0];
      rem_r <= '0;
      den_r <= divisor;
      neg_r <= dividend[PROD_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

[hdl/rbe_seq.sv]
// rbe_seq: program counter and microcode fetch with conditional jumps.
// Uses rbe_pkg for the control word layout and the program table.
module rbe_seq import rbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output uword_t    uw
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            cond;

  assign uw = ucode(pc_r);

  always_comb begin
    case (uw.jc)
      JC_NONE:      cond = 1'b0;
      JC_ALWAYS:    cond = 1'b1;
      JC_IN_XFER:   cond = stat.in_xfer;
      JC_CMD_FORCE: cond = stat.dp.cmd_force;
      JC_KINEM:     cond = stat.kinematic;
      JC_MODE_VC:   cond = (stat.dp.mode == FM_VEL_CHANGE);
      JC_MODE_ACC:  cond = (stat.dp.mode == FM_ACCEL);
      JC_DIV_IDLE:  cond = stat.div_idle;
      JC_AXIS_MORE: cond = stat.dp.axis_more;
      JC_OUT_FREE:  cond = stat.out_free;
      default:      cond = 1'b0;
    endcase
    if (cond) pc_nxt = uw.target;
    else if (uw.hold) pc_nxt = pc_r;
    else pc_nxt = pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= PC_IDLE;
    else pc_r <= pc_nxt;
  end

endmodule

[hdl/rbe_dp.sv]
// rbe_dp: datapath with position/velocity state, shared multiplier,
// working accumulator and gravity term, steered by the microcode word.
// Uses rbe_pkg.
module rbe_dp import rbe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  uword_t                   uw,
  input  logic                     in_xfer,
  input  logic                     in_cmd,
  input  logic [1:0]               in_mode,
  input  axis_vec_t                in_force,
  input  logic [MASS_W-1:0]        eff_mass,
  input  logic [DRAG_W-1:0]        drag,
  input  logic                     use_gravity,
  input  logic [AXES-1:0]          constraint_mask,
  input  logic [STEP_W-1:0]        step_size,
  input  logic [STEP_W-1:0]        gravity_step,
  input  logic signed [QUOT_W-1:0] quot,
  output logic signed [PROD_W-1:0] dividend,
  output dp_stat_t                 stat,
  output axis_vec_t                pos,
  output axis_vec_t                vel
);

  axis_vec_t                pos_r, vel_r, force_r;
  logic                     cmd_r;
  force_mode_t              mode_r;
  logic [AXIS_W-1:0]        axis_r;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic [GRAV_W-1:0]        grav_r;

  logic signed [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]               mul_b;
  logic signed [MA_W+MB_W:0]     prod_full;
  logic signed [PROD_W-1:0]      prod_adj, prod_q;
  logic signed [PROD_W-1:0]      vel_cur, force_cur, grav_sub;
  logic signed [32:0]            pos_sum;
  logic signed [PROD_W-1:0]      vel_sub, vel_add;
  logic                          axis_more;

  assign vel_cur   = PROD_W'($signed(vel_r[axis_r]));
  assign force_cur = PROD_W'($signed(force_r[axis_r]));
  assign axis_more = (axis_r != AX_Z);

  always_comb begin
    case (uw.mul_a)
      MA_FORCE: mul_a = MA_W'($signed(force_r[axis_r]));
      MA_VEL:   mul_a = MA_W'($signed(vel_r[axis_r]));
      MA_ACC:   mul_a = acc_r[MA_W-1:0];
      MA_MASS:  mul_a = {{(MA_W-MASS_W){1'b0}}, eff_mass};
      default:  mul_a = '0;
    endcase
    case (uw.mul_b)
      MB_STEP:   mul_b = {{(MB_W-STEP_W){1'b0}}, step_size};
      MB_DRAG:   mul_b = drag;
      MB_GSTEP:  mul_b = {{(MB_W-STEP_W){1'b0}}, gravity_step};
      MB_FSCALE: mul_b = (mode_r == FM_IMPULSE) ? Q_ONE
                                                : {{(MB_W-STEP_W){1'b0}}, step_size};
      default:   mul_b = '0;
    endcase
  end

  assign prod_full = mul_a * $signed({1'b0, mul_b});

  // product over 65536, truncated toward zero
  assign prod_adj = prod_r + {{(PROD_W-16){1'b0}}, {16{prod_r[PROD_W-1]}}};
  assign prod_q   = {{16{prod_adj[PROD_W-1]}}, prod_adj[PROD_W-1:16]};

  assign pos_sum  = 33'($signed(pos_r[axis_r])) + 33'($signed(vel_r[axis_r]));
  assign grav_sub = (axis_r == AX_Y && use_gravity)
                    ? {{(PROD_W-GRAV_W){1'b0}}, grav_r} : '0;
  assign vel_sub  = vel_cur - acc_r - grav_sub;
  assign vel_add  = vel_cur + acc_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      force_r <= in_force;
      cmd_r   <= in_cmd;
      mode_r  <= force_mode_t'(in_mode);
    end
    if (uw.mul_en) prod_r <= prod_full[PROD_W-1:0];
    case (uw.acc_op)
      ACC_NONE:   acc_r <= acc_r;
      ACC_PROD_Q: acc_r <= prod_q;
      ACC_QUOT:   acc_r <= PROD_W'(quot);
      ACC_FORCE:  acc_r <= force_cur;
      default:    acc_r <= acc_r;
    endcase
    if (uw.st_op == ST_GRAV) grav_r <= prod_q[GRAV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      vel_r  <= '0;
      axis_r <= '0;
    end else begin
      if (in_xfer) axis_r <= '0;
      else if (uw.axis_step) axis_r <= axis_more ? axis_r + 1'b1 : '0;
      case (uw.st_op)
        ST_POS: begin
          if (!constraint_mask[axis_r]) pos_r[axis_r] <= sat32(PROD_W'(pos_sum));
        end
        ST_VEL_SUB: vel_r[axis_r] <= sat32(vel_sub);
        ST_VEL_ADD: vel_r[axis_r] <= sat32(vel_add);
        default: ;
      endcase
    end
  end

  assign dividend       = prod_r;
  assign stat.cmd_force = (cmd_r == CMD_FORCE);
  assign stat.mode      = mode_r;
  assign stat.axis_more = axis_more;
  assign pos            = pos_r;
  assign vel            = vel_r;

endmodule

[hdl/rigid_body_euler_step.sv]
// rigid_body_euler_step: top level with configuration registers, result
// register and stream ports. Depends on rbe_pkg, rbe_seq, rbe_dp, rbe_div.
//
// Usage: each transfer on the in_ channel is one command. command 0 is a
// tick (move positions by velocity, then drag and gravity on velocity),
// command 1 adds a force in force_mode to the velocity. Every command
// yields one transfer on the out_ channel carrying position and velocity
// after the command. Registers are to be written through cfg_we/cfg_addr/
// cfg_wdata only while no command is in flight; the block does not enforce it.
// Force and impulse commands run the shared one-bit-per-cycle divider once
// for each of the three axes, dividing by the mass; acceleration and
// velocity change skip it, and a kinematic tick goes straight to the output.
// in_tready is high only while the microcode sits on its idle word, which
// it reaches in the cycle after the result is handed to the output register.
// The result register lets the next command start while a result waits;
// if out_tready stays low the program holds at its output step.
// Reset (rst_n low, synchronous) zeroes position and velocity, loads the
// register defaults and returns the program counter to idle.
module rigid_body_euler_step import rbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,   // force_x, force_y, force_z
  input  logic [2:0]            in_tuser,   // command, force_mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [191:0]          out_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [MASS_W-1:0] mass_r;
  logic [DRAG_W-1:0] drag_r;
  logic              use_gravity_r;
  logic [AXES-1:0]   constraint_r;
  logic              kinematic_r;
  logic [STEP_W-1:0] step_size_r;
  logic [STEP_W-1:0] gravity_step_r;

  logic              out_valid_r;
  logic [191:0]      out_data_r;

  uword_t                   uw;
  seq_stat_t                sstat;
  dp_stat_t                 dstat;
  logic                     in_xfer, out_free, div_busy;
  logic [MASS_W-1:0]        eff_mass;
  logic signed [PROD_W-1:0] dividend;
  logic signed [QUOT_W-1:0] quot;
  axis_vec_t                in_force, pos, vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r         <= MASS_RST;
      drag_r         <= '0;
      use_gravity_r  <= 1'b1;
      constraint_r   <= '0;
      kinematic_r    <= 1'b0;
      step_size_r    <= STEP_RST;
      gravity_step_r <= GSTEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MASS:         mass_r         <= cfg_wdata[MASS_W-1:0];
        CFG_DRAG:         drag_r         <= cfg_wdata[DRAG_W-1:0];
        CFG_USE_GRAVITY:  use_gravity_r  <= cfg_wdata[0];
        CFG_CONSTRAINT:   constraint_r   <= cfg_wdata[AXES-1:0];
        CFG_KINEMATIC:    kinematic_r    <= cfg_wdata[0];
        CFG_STEP_SIZE:    step_size_r    <= cfg_wdata[STEP_W-1:0];
        CFG_GRAVITY_STEP: gravity_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero mass acts as one lsb
  assign eff_mass = (mass_r == '0) ? MASS_W'(1) : mass_r;

  assign in_tready = uw.rdy;
  assign in_xfer   = in_tvalid & uw.rdy;
  assign out_free  = !out_valid_r || out_tready;
  assign in_force  = {in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};

  assign sstat.dp        = dstat;
  assign sstat.in_xfer   = in_xfer;
  assign sstat.kinematic = kinematic_r;
  assign sstat.div_idle  = !div_busy;
  assign sstat.out_free  = out_free;

  rbe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (sstat),
    .uw    (uw)
  );

  rbe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .uw              (uw),
    .in_xfer         (in_xfer),
    .in_cmd          (in_tuser[0]),
    .in_mode         (in_tuser[2:1]),
    .in_force        (in_force),
    .eff_mass        (eff_mass),
    .drag            (drag_r),
    .use_gravity     (use_gravity_r),
    .constraint_mask (constraint_r),
    .step_size       (step_size_r),
    .gravity_step    (gravity_step_r),
    .quot            (quot),
    .dividend        (dividend),
    .stat            (dstat),
    .pos             (pos),
    .vel             (vel)
  );

  rbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uw.div_start),
    .dividend (dividend),
    .divisor  (eff_mass),
    .busy     (div_busy),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_load && out_free) out_data_r <= {vel, pos};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[dv/rbe_state_checker.sv]
// rbe_state_checker: watches the command, result and register ports of the
// rigid body euler step block, tracks the body state and compares every result.
// Depends on rbe_pkg for port widths, command codes and register indexes.
`timescale 1ns / 100ps

module rbe_state_checker import rbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [95:0]          in_tdata,   // force_x, force_y, force_z
  input  logic [2:0]           in_tuser,   // command, force_mode
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [191:0]         out_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam longint Q16     = 65536;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  longint          body_pos [AXES];
  longint          body_vel [AXES];
  longint          mass_q;
  longint          drag_q;
  longint          step_q;
  longint          gstep_q;
  logic            grav_on;
  logic            kin_on;
  logic [AXES-1:0] frozen;
  logic [191:0]    body_state_q [$];
  string           field_names [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // a zero mass register behaves as one lsb
  function automatic longint mass_divisor();
    return (mass_q == 0) ? 1 : mass_q;
  endfunction

  function automatic longint velocity_delta(input longint f, input force_mode_t mode);
    case (mode)
      FM_FORCE:   return (f * step_q) / mass_divisor();
      FM_ACCEL:   return (f * step_q) / Q16;
      FM_IMPULSE: return (f * Q16) / mass_divisor();
      default:    return f;
    endcase
  endfunction

  function automatic logic [191:0] advance_body(input cmd_t cmd, input force_mode_t mode,
                                                input logic [95:0] forces);
    logic [191:0] snap;
    longint       v;
    longint       t;
    int           a;
    if (cmd == CMD_FORCE) begin
      for (a = 0; a < AXES; a++)
        body_vel[a] = clamp32(body_vel[a] +
                              velocity_delta(longint'($signed(forces[32*a +: 32])), mode));
    end else if (!kin_on) begin
      // positions move with the velocity from before drag and gravity
      for (a = 0; a < AXES; a++)
        if (!frozen[a]) body_pos[a] = clamp32(body_pos[a] + body_vel[a]);
      for (a = 0; a < AXES; a++) begin
        v = body_vel[a];
        t = (v * drag_q) / Q16;
        v = v - (t * step_q) / Q16;
        if (a == AX_Y && grav_on) v = v - (gstep_q * mass_divisor()) / Q16;
        body_vel[a] = clamp32(v);
      end
    end
    for (a = 0; a < AXES; a++) begin
      snap[32*a +: 32]        = body_pos[a][31:0];
      snap[32*(AXES+a) +: 32] = body_vel[a][31:0];
    end
    return snap;
  endfunction

  always @(posedge clk) begin
    logic [191:0] want;
    int           k;
    if (!rst_n) begin
      mass_q     = MASS_RST;
      drag_q     = 0;
      grav_on    = 1'b1;
      frozen     = '0;
      kin_on     = 1'b0;
      step_q     = STEP_RST;
      gstep_q    = GSTEP_RST;
      fail_count = 0;
      for (k = 0; k < AXES; k++) begin
        body_pos[k] = 0;
        body_vel[k] = 0;
      end
      body_state_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_MASS:         mass_q  = cfg_wdata[MASS_W-1:0];
          CFG_DRAG:         drag_q  = cfg_wdata[DRAG_W-1:0];
          CFG_USE_GRAVITY:  grav_on = cfg_wdata[0];
          CFG_CONSTRAINT:   frozen  = cfg_wdata[AXES-1:0];
          CFG_KINEMATIC:    kin_on  = cfg_wdata[0];
          CFG_STEP_SIZE:    step_q  = cfg_wdata[STEP_W-1:0];
          CFG_GRAVITY_STEP: gstep_q = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (body_state_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = body_state_q.pop_front();
          for (k = 0; k < 6; k++)
            if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
              $error("%s expected %0d, got %0d", field_names[k],
                     $signed(want[32*k +: 32]), $signed(out_tdata[32*k +: 32]));
              fail_count++;
            end
        end
      end
      if (in_tvalid && in_tready)
        body_state_q.push_back(advance_body(cmd_t'(in_tuser[0]), force_mode_t'(in_tuser[2:1]),
                                            in_tdata));
      pending <= body_state_q.size();
    end
  end

endmodule

[dv/tb_rigid_body_euler_step.sv]
// tb_rigid_body_euler_step: drives commands and register writes into the rigid
// body euler step block with random idling and back-pressure; rbe_state_checker
// does the checking. Depends on rbe_pkg, rbe_state_checker and the block.
`timescale 1ns / 100ps

module tb_rigid_body_euler_step import rbe_pkg::*;;

  localparam int                   RAND_PHASES     = 13;
  localparam int                   ITEMS_PER_PHASE = 150;
  localparam int                   RX_HOLD_CYCLES  = 400;
  localparam int                   TAIL_CYCLES     = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [95:0]          in_tdata;   // force_x, force_y, force_z
  logic [2:0]           in_tuser;   // command, force_mode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [191:0]         out_tdata;  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  logic                 calm;
  logic                 hold_trigger;
  logic                 hold_done;

  rigid_body_euler_step uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  rbe_state_checker body_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger && !hold_done) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(99) < 34) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input force_mode_t mode,
                           input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz);
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fz, fy, fx};
    in_tuser  <= {mode, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] mass, input logic [CFG_W-1:0] drag,
                           input logic [CFG_W-1:0] grav, input logic [CFG_W-1:0] mask,
                           input logic [CFG_W-1:0] kin, input logic [CFG_W-1:0] step,
                           input logic [CFG_W-1:0] gstep);
    write_reg(CFG_MASS, mass);
    write_reg(CFG_DRAG, drag);
    write_reg(CFG_USE_GRAVITY, grav);
    write_reg(CFG_CONSTRAINT, mask);
    write_reg(CFG_KINEMATIC, kin);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_GRAVITY_STEP, gstep);
    // unmapped index must not disturb anything
    write_reg(CFG_SPARE, CFG_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait until every result has been taken
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_force();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return $urandom();
      default: return $urandom_range(32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_reg(input cfg_idx_t idx);
    logic [2:0] pick;
    pick = 3'($urandom_range(7));
    // occasionally full-width junk so the unused upper bits get exercised
    if (pick == 0) return CFG_W'($urandom());
    case (idx)
      CFG_MASS: begin
        case (pick)
          1:       return '0;
          2:       return 1;
          3:       return 31'h7fff_ffff;
          default: return CFG_W'($urandom_range(32'h0010_0000, 32'h0000_0400));
        endcase
      end
      CFG_DRAG: begin
        case (pick)
          1:       return '0;
          2:       return 31'h100_0000;
          default: return CFG_W'($urandom_range(32'h0004_0000));
        endcase
      end
      CFG_USE_GRAVITY: return CFG_W'(pick[0]);
      CFG_CONSTRAINT:  return CFG_W'($urandom_range(7));
      CFG_KINEMATIC:   return CFG_W'(pick == 1);
      default: begin
        case (pick)
          1:       return '0;
          2:       return 65536;
          default: return CFG_W'($urandom_range(32'h0000_1000));
        endcase
      end
    endcase
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_trigger = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: gravity on, no drag, unit mass
    send_item(CMD_TICK, FM_FORCE, '0, '0, '0);
    send_item(CMD_FORCE, FM_VEL_CHANGE, 32'h7fff_ffff, 32'h8000_0000, '0);
    send_item(CMD_FORCE, FM_VEL_CHANGE, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
    send_item(CMD_TICK, FM_VEL_CHANGE, '0, '0, '0);
    send_item(CMD_TICK, FM_IMPULSE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_FORCE, FM_FORCE, 32'h8000_0000, 32'h7fff_ffff, 32'd1);
    send_item(CMD_FORCE, FM_ACCEL, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
    send_item(CMD_FORCE, FM_IMPULSE, 32'hffff_0000, 32'h0001_0000, 32'h1234_5678);

    // zero mass, heavy drag, unit step, x and z frozen
    wait_idle();
    configure('0, 31'h100_0000, 1, 5, 0, 65536, 65536);
    send_item(CMD_FORCE, FM_IMPULSE, 32'd1, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(CMD_FORCE, FM_FORCE, 32'h0000_8000, 32'h8000_0000, 32'hffff_ffff);
    send_item(CMD_TICK, FM_ACCEL, '0, '0, '0);
    send_item(CMD_TICK, FM_FORCE, '0, '0, '0);

    // kinematic, gravity off, every other register at its top value
    wait_idle();
    configure(31'h7fff_ffff, 31'h1ff_ffff, 0, 7, 1, 31'h1_ffff, 31'h1_ffff);
    send_item(CMD_TICK, FM_FORCE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(CMD_FORCE, FM_VEL_CHANGE, 32'd5, 32'hffff_fffb, 32'd7);
    send_item(CMD_TICK, FM_FORCE, '0, '0, '0);

    // all axes frozen, gravity with maximum mass
    wait_idle();
    configure(31'h7fff_ffff, 32768, 1, 7, 0, 31'h1_ffff, 31'h1_ffff);
    send_item(CMD_TICK, FM_FORCE, '0, '0, '0);
    send_item(CMD_FORCE, FM_VEL_CHANGE, 32'hffff_ffff, 32'd1, 32'hffff_0000);
    send_item(CMD_TICK, FM_FORCE, '0, '0, '0);
    send_item(CMD_FORCE, FM_ACCEL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CMD_FORCE, FM_FORCE, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      configure(random_reg(CFG_MASS), random_reg(CFG_DRAG), random_reg(CFG_USE_GRAVITY),
                random_reg(CFG_CONSTRAINT), random_reg(CFG_KINEMATIC),
                random_reg(CFG_STEP_SIZE), random_reg(CFG_GRAVITY_STEP));
      calm <= (ph == 3);
      if (ph == 1) hold_trigger <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(cmd_t'($urandom_range(1)), force_mode_t'($urandom_range(3)),
                  random_force(), random_force(), random_force());
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
